// ----- hdl/fha_pkg.sv -----
// Shared types, widths and codes of the first-fit heap allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package fha_pkg;

  // Default sizing of the heap.
  localparam int HEAP_UNITS_MAX_DEF  = 4096;
  localparam int ALIGN_BYTES_DEF     = 4;
  localparam int HEADER_UNITS_DEF    = 3;
  localparam int MIN_SPLIT_UNITS_DEF = 3;

  // Fixed field widths of the channels and of the register.
  localparam int KIND_W = 2;
  localparam int SIZE_W = 16;
  localparam int ADDR_W = 14;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 13;

  localparam logic [CFG_W-1:0] HEAP_UNITS_RST = 13'd4096;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REALLOC = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_SIZE     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOMEM    = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_BADADDR  = 2'd3;

  // Sequencer steps; the controller state doubles as the datapath command.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_INIT0 = 5'd0;
  localparam logic [OP_W-1:0] OP_INIT1 = 5'd1;
  localparam logic [OP_W-1:0] OP_IDLE  = 5'd2;
  localparam logic [OP_W-1:0] OP_ACHK  = 5'd3;
  localparam logic [OP_W-1:0] OP_FFRD  = 5'd4;
  localparam logic [OP_W-1:0] OP_FFEV  = 5'd5;
  localparam logic [OP_W-1:0] OP_SP1   = 5'd6;
  localparam logic [OP_W-1:0] OP_SP2   = 5'd7;
  localparam logic [OP_W-1:0] OP_RLRD  = 5'd8;
  localparam logic [OP_W-1:0] OP_RLEV  = 5'd9;
  localparam logic [OP_W-1:0] OP_LCHK  = 5'd10;
  localparam logic [OP_W-1:0] OP_LRD   = 5'd11;
  localparam logic [OP_W-1:0] OP_LEV   = 5'd12;
  localparam logic [OP_W-1:0] OP_RCHK  = 5'd13;
  localparam logic [OP_W-1:0] OP_RA1   = 5'd14;
  localparam logic [OP_W-1:0] OP_RA2   = 5'd15;
  localparam logic [OP_W-1:0] OP_SC    = 5'd16;
  localparam logic [OP_W-1:0] OP_S2    = 5'd17;
  localparam logic [OP_W-1:0] OP_S3    = 5'd18;
  localparam logic [OP_W-1:0] OP_S4    = 5'd19;
  localparam logic [OP_W-1:0] OP_RG    = 5'd20;
  localparam logic [OP_W-1:0] OP_RG2   = 5'd21;
  localparam logic [OP_W-1:0] OP_R0    = 5'd22;
  localparam logic [OP_W-1:0] OP_R1    = 5'd23;
  localparam logic [OP_W-1:0] OP_R2    = 5'd24;
  localparam logic [OP_W-1:0] OP_R3    = 5'd25;
  localparam logic [OP_W-1:0] OP_R4    = 5'd26;
  localparam logic [OP_W-1:0] OP_R5    = 5'd27;
  localparam logic [OP_W-1:0] OP_R6    = 5'd28;
  localparam logic [OP_W-1:0] OP_DONE  = 5'd29;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            accept;
    logic            out_load;
  } fha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic asz_bad;
    logic rsz_bad;
    logic at_end;
    logic fit;
    logic ff_split;
    logic rl_stop;
    logic addr_bad;
    logic found;
    logic cont;
    logic grow;
    logic move;
    logic sc_split;
    logic below;
    logic xfree;
    logic nfree;
    logic pfree;
    logic mv;
    logic out_busy;
  } fha_stat_t;

endpackage

// ----- hdl/fha_req_if.sv -----
// Request channel of the heap allocator: valid, ready and the request fields.
// Depends on fha_pkg for the field widths.
interface fha_req_if;
  logic                        valid;
  logic                        ready;
  logic [fha_pkg::KIND_W-1:0]  kind;
  logic [fha_pkg::SIZE_W-1:0]  size_bytes;
  logic [fha_pkg::ADDR_W-1:0]  address_bytes;

  modport source (output valid, kind, size_bytes, address_bytes, input ready);
  modport sink   (input valid, kind, size_bytes, address_bytes, output ready);
endinterface

// ----- hdl/fha_rsp_if.sv -----
// Result channel of the heap allocator: valid, ready and the result fields.
// Depends on fha_pkg for the field widths.
interface fha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [fha_pkg::STAT_W-1:0]  status;
  logic [fha_pkg::ADDR_W-1:0]  result_address;
  logic                        moved;
  logic [fha_pkg::ADDR_W-1:0]  old_address;
  logic [fha_pkg::ADDR_W-1:0]  copy_bytes;

  modport source (output valid, status, result_address, moved, old_address, copy_bytes,
                  input ready);
  modport sink   (input valid, status, result_address, moved, old_address, copy_bytes,
                  output ready);
endinterface

// ----- hdl/first_fit_heap_allocator_core.sv -----
// Top level of the first-fit heap allocator: channels, register port, controller, datapath.
// Depends on fha_pkg, fha_req_if, fha_rsp_if, fha_ctrl and fha_dp.
//
// Usage: requests (alloc, free, realloc) arrive on the req channel and one result per
// request leaves on the rsp channel; a transfer happens when valid and ready are both high.
// Requests are handled one at a time. An alloc walks the block headers from the first-free
// hint, splits the chosen block when the rest is large enough, and then updates the hint.
// Free and realloc first walk the block chain from granule 0 to check the address. A realloc
// in place may then update the hint as well; a realloc that moves adds a full alloc search
// and a free of the old block.
// The header memory takes one write and one registered read per cycle.
// Writing cfg_wdata with cfg_we rebuilds the heap as one free block, and no request is
// taken while it does; reset does the same with the full heap length.
// A result waits in the output register while the receiver stalls; the next request is
// taken meanwhile, and its result is held back until the earlier one is transferred.
module first_fit_heap_allocator_core #(
  parameter int HEAP_UNITS_MAX  = fha_pkg::HEAP_UNITS_MAX_DEF,
  parameter int ALIGN_BYTES     = fha_pkg::ALIGN_BYTES_DEF,
  parameter int HEADER_UNITS    = fha_pkg::HEADER_UNITS_DEF,
  parameter int MIN_SPLIT_UNITS = fha_pkg::MIN_SPLIT_UNITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  fha_req_if.sink                   req,
  fha_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [fha_pkg::CFG_W-1:0] cfg_wdata
);
  import fha_pkg::*;

  fha_cmd_t  cmd;
  fha_stat_t stat;

  // Step sequencer.
  fha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cfg_we    (cfg_we),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Header memory and arithmetic.
  fha_dp #(
    .HEAP_UNITS_MAX  (HEAP_UNITS_MAX),
    .ALIGN_BYTES     (ALIGN_BYTES),
    .HEADER_UNITS    (HEADER_UNITS),
    .MIN_SPLIT_UNITS (MIN_SPLIT_UNITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_kind   (req.kind),
    .req_size   (req.size_bytes),
    .req_addr   (req.address_bytes),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_result (rsp.result_address),
    .rsp_moved  (rsp.moved),
    .rsp_old    (rsp.old_address),
    .rsp_copy   (rsp.copy_bytes)
  );

endmodule

// ----- hdl/fha_ctrl.sv -----
// Sequencing state machine of the heap allocator.
// Depends on fha_pkg for the step codes and the command and status structs.
module fha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               cfg_we,
  input  fha_pkg::fha_stat_t stat,
  output fha_pkg::fha_cmd_t  cmd
);
  import fha_pkg::*;

  logic [OP_W-1:0] state;
  logic [OP_W-1:0] state_next;

  // Requests are taken only between operations.
  assign req_ready    = (state == OP_IDLE);
  assign cmd.op       = state;
  assign cmd.accept   = (state == OP_IDLE) && req_valid;
  assign cmd.out_load = (state == OP_DONE) && !stat.out_busy;

  // Next step of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      OP_INIT0: state_next = OP_INIT1;
      OP_INIT1: state_next = OP_IDLE;
      OP_IDLE: begin
        if (req_valid) begin
          if (stat.kind == KIND_ALLOC) state_next = OP_ACHK;
          else if (stat.kind == KIND_FREE || stat.kind == KIND_REALLOC) state_next = OP_LCHK;
          else state_next = OP_DONE;
        end
      end
      OP_ACHK: state_next = stat.asz_bad ? OP_DONE : OP_FFRD;
      OP_FFRD: state_next = stat.at_end ? OP_DONE : OP_FFEV;
      OP_FFEV: begin
        if (stat.fit) state_next = stat.ff_split ? OP_SP1 : OP_RLRD;
        else state_next = OP_FFRD;
      end
      OP_SP1: state_next = OP_SP2;
      OP_SP2: state_next = OP_RLRD;
      OP_RLRD: state_next = OP_RLEV;
      OP_RLEV: begin
        if (!stat.rl_stop) state_next = OP_RLRD;
        else if (stat.kind == KIND_REALLOC && stat.mv) state_next = OP_RG;
        else state_next = OP_DONE;
      end
      OP_LCHK: state_next = stat.addr_bad ? OP_DONE : OP_LRD;
      OP_LRD: state_next = OP_LEV;
      OP_LEV: begin
        if (stat.found) state_next = (stat.kind == KIND_FREE) ? OP_R0 : OP_RCHK;
        else if (stat.cont) state_next = OP_LRD;
        else state_next = OP_DONE;
      end
      OP_RCHK: begin
        if (stat.rsz_bad) state_next = OP_DONE;
        else state_next = stat.grow ? OP_RA1 : OP_SC;
      end
      OP_RA1: state_next = stat.move ? OP_FFRD : OP_RA2;
      OP_RA2: state_next = OP_SC;
      OP_SC: begin
        if (stat.sc_split) state_next = OP_S2;
        else state_next = stat.below ? OP_RLRD : OP_DONE;
      end
      OP_S2: state_next = OP_S3;
      OP_S3: begin
        if (stat.xfree) state_next = OP_S4;
        else state_next = stat.below ? OP_RLRD : OP_DONE;
      end
      OP_S4: state_next = stat.below ? OP_RLRD : OP_DONE;
      OP_RG:  state_next = OP_RG2;
      OP_RG2: state_next = OP_R0;
      OP_R0:  state_next = OP_R1;
      OP_R1:  state_next = stat.nfree ? OP_R2 : OP_R3;
      OP_R2:  state_next = OP_R3;
      OP_R3:  state_next = OP_R4;
      OP_R4:  state_next = stat.pfree ? OP_R5 : OP_R6;
      OP_R5:  state_next = OP_R6;
      OP_R6:  state_next = OP_DONE;
      OP_DONE: state_next = stat.out_busy ? OP_DONE : OP_IDLE;
      default: state_next = OP_INIT0;
    endcase
  end

  // A register write rebuilds the heap, so it restarts at the first setup step.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= OP_INIT0;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/fha_dp.sv -----
// Datapath of the heap allocator: header memory, working registers and result register.
// Depends on fha_pkg; driven step by step by fha_ctrl.
module fha_dp #(
  parameter int HEAP_UNITS_MAX  = fha_pkg::HEAP_UNITS_MAX_DEF,
  parameter int ALIGN_BYTES     = fha_pkg::ALIGN_BYTES_DEF,
  parameter int HEADER_UNITS    = fha_pkg::HEADER_UNITS_DEF,
  parameter int MIN_SPLIT_UNITS = fha_pkg::MIN_SPLIT_UNITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fha_pkg::fha_cmd_t           cmd,
  output fha_pkg::fha_stat_t          stat,
  input  logic                        cfg_we,
  input  logic [fha_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [fha_pkg::KIND_W-1:0]  req_kind,
  input  logic [fha_pkg::SIZE_W-1:0]  req_size,
  input  logic [fha_pkg::ADDR_W-1:0]  req_addr,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [fha_pkg::STAT_W-1:0]  rsp_status,
  output logic [fha_pkg::ADDR_W-1:0]  rsp_result,
  output logic                        rsp_moved,
  output logic [fha_pkg::ADDR_W-1:0]  rsp_old,
  output logic [fha_pkg::ADDR_W-1:0]  rsp_copy
);
  import fha_pkg::*;

  localparam int GW = $clog2(HEAP_UNITS_MAX);
  localparam int HW = 2 * GW + 1;
  localparam int UW = SIZE_W + 1;

  // Header memory: used mark, previous link, next link.
  logic [HW-1:0] mem [HEAP_UNITS_MAX];
  logic [HW-1:0] rdata;
  logic          we;
  logic          re;
  logic [GW-1:0] waddr;
  logic [GW-1:0] raddr;
  logic [HW-1:0] wdata;

  // Working registers.
  logic [CFG_W-1:0]  heap_units;
  logic [KIND_W-1:0] kind;
  logic [UW-1:0]     units;
  logic [ADDR_W-1:0] addr_b;
  logic [GW-1:0]     hint, start, cur, ng, onext, onext2, sreg, rl, g, gprev, gnext;
  logic              mv;
  logic [ADDR_W-1:0] copyb;
  logic [STAT_W-1:0] res_status;
  logic [ADDR_W-1:0] res_result, res_old, res_copy;
  logic              res_moved;

  // Derived values.
  logic [31:0]   hu_cl, q32, hope32, s_ff32, s_sc32, node32;
  logic [GW-1:0] e_g, t, s_ff, s_sc;
  logic          r_used;
  logic [GW-1:0] r_prev, r_next;
  logic          misal;
  logic [ADDR_W-1:0] copy_c;

  function automatic logic [ADDR_W-1:0] pay(input logic [GW-1:0] x);
    pay = ADDR_W'((32'(x) + HEADER_UNITS) * ALIGN_BYTES);
  endfunction

  assign r_used = rdata[HW-1];
  assign r_prev = rdata[2*GW-1:GW];
  assign r_next = rdata[GW-1:0];

  // Heap length clamped to its legal range, and the end header granule.
  always_comb begin
    hu_cl = 32'(heap_units);
    if (hu_cl < 32'(2 * HEADER_UNITS)) hu_cl = 32'(2 * HEADER_UNITS);
    if (hu_cl > 32'(HEAP_UNITS_MAX)) hu_cl = 32'(HEAP_UNITS_MAX);
  end
  assign e_g = GW'(hu_cl - 32'(HEADER_UNITS));

  // Address and size arithmetic.
  assign q32    = 32'(addr_b) / ALIGN_BYTES;
  assign misal  = (32'(addr_b) % ALIGN_BYTES) != 32'd0;
  assign t      = GW'(q32 - 32'(HEADER_UNITS));
  assign hope32 = 32'(HEADER_UNITS) + 32'(units);
  assign s_ff32 = 32'(cur) + hope32;
  assign s_sc32 = 32'(g) + hope32;
  assign s_ff   = GW'(s_ff32);
  assign s_sc   = GW'(s_sc32);
  assign node32 = 32'(gnext) - 32'(g);
  assign copy_c = (node32 > 32'(HEADER_UNITS)) ?
                  ADDR_W'((node32 - 32'(HEADER_UNITS)) * ALIGN_BYTES) : '0;

  // Status towards the controller.
  always_comb begin
    stat.kind     = (cmd.op == OP_IDLE) ? req_kind : kind;
    stat.asz_bad  = (units == '0) || (32'(units) > 32'(e_g));
    stat.rsz_bad  = 32'(units) > 32'(e_g);
    stat.at_end   = (cur == e_g);
    stat.fit      = !r_used && (r_next > cur) && (32'(r_next - cur) >= hope32);
    stat.ff_split = (32'(r_next) >= s_ff32) &&
                    ((32'(r_next) - s_ff32) >= 32'(MIN_SPLIT_UNITS));
    stat.rl_stop  = !r_used || (r_next == e_g);
    stat.addr_bad = misal || (q32 < 32'(HEADER_UNITS)) || (q32 >= 32'(e_g));
    stat.found    = (cur == t) && r_used;
    stat.cont     = (cur < t) && (cur != e_g);
    stat.grow     = hope32 > node32;
    stat.move     = r_used || (hope32 > (32'(r_next) - 32'(g)));
    stat.sc_split = (32'(gnext) >= s_sc32) &&
                    ((32'(gnext) - s_sc32) >= 32'(MIN_SPLIT_UNITS));
    stat.below    = g < hint;
    stat.xfree    = !r_used;
    stat.nfree    = !r_used;
    stat.pfree    = !r_used;
    stat.mv       = mv;
    stat.out_busy = rsp_valid && !rsp_ready;
  end

  // Memory port control for each step.
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = '0;
    unique case (cmd.op)
      OP_INIT0: begin
        we = 1'b1; waddr = '0; wdata = {1'b0, e_g, e_g};
      end
      OP_INIT1: begin
        we = 1'b1; waddr = e_g; wdata = {1'b1, {GW{1'b0}}, {GW{1'b0}}};
      end
      OP_FFRD: begin
        re = 1'b1; raddr = cur;
      end
      OP_FFEV: begin
        we = stat.fit; waddr = cur;
        wdata = {1'b1, r_prev, stat.ff_split ? s_ff : r_next};
      end
      OP_SP1: begin
        we = 1'b1; waddr = sreg; wdata = {1'b0, ng, onext};
        re = 1'b1; raddr = onext;
      end
      OP_SP2: begin
        we = 1'b1; waddr = onext; wdata = {r_used, sreg, r_next};
      end
      OP_RLRD: begin
        re = 1'b1; raddr = rl;
      end
      OP_LRD: begin
        re = 1'b1; raddr = cur;
      end
      OP_RCHK: begin
        re = 1'b1; raddr = gnext;
      end
      OP_RA1: begin
        we = !stat.move; waddr = g; wdata = {1'b1, gprev, r_next};
        re = 1'b1; raddr = r_next;
      end
      OP_RA2: begin
        we = 1'b1; waddr = gnext; wdata = {r_used, g, r_next};
      end
      OP_SC: begin
        we = stat.sc_split; waddr = g; wdata = {1'b1, gprev, s_sc};
      end
      OP_S2: begin
        we = 1'b1; waddr = sreg; wdata = {1'b0, g, onext};
        re = 1'b1; raddr = onext;
      end
      OP_S3: begin
        we = 1'b1;
        if (!r_used) begin
          waddr = sreg; wdata = {1'b0, g, r_next};
        end else begin
          waddr = onext; wdata = {r_used, sreg, r_next};
        end
        re = 1'b1; raddr = r_next;
      end
      OP_S4: begin
        we = 1'b1; waddr = onext2; wdata = {r_used, sreg, r_next};
      end
      OP_RG: begin
        re = 1'b1; raddr = g;
      end
      OP_R0: begin
        we = 1'b1; waddr = g; wdata = {1'b0, gprev, gnext};
        re = 1'b1; raddr = gnext;
      end
      OP_R1: begin
        we = !r_used; waddr = g; wdata = {1'b0, gprev, r_next};
        re = 1'b1; raddr = r_next;
      end
      OP_R2: begin
        we = 1'b1; waddr = gnext; wdata = {r_used, g, r_next};
      end
      OP_R3: begin
        re = 1'b1; raddr = gprev;
      end
      OP_R4: begin
        we = !r_used; waddr = gprev; wdata = {1'b0, r_prev, gnext};
        re = 1'b1; raddr = gnext;
      end
      OP_R5: begin
        we = 1'b1; waddr = gnext; wdata = {r_used, g, r_next};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Header memory with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Working registers, updated per step.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind       <= req_kind;
      units      <= UW'((32'(req_size) + ALIGN_BYTES - 1) / ALIGN_BYTES);
      addr_b     <= req_addr;
      mv         <= 1'b0;
      res_status <= STATUS_OK;
      res_result <= '0;
      res_moved  <= 1'b0;
      res_old    <= '0;
      res_copy   <= '0;
    end
    unique case (cmd.op)
      OP_INIT1: hint <= '0;
      OP_ACHK: begin
        if (stat.asz_bad) res_status <= STATUS_SIZE;
        start <= hint;
        cur   <= hint;
      end
      OP_FFRD: begin
        if (stat.at_end) res_status <= STATUS_NOMEM;
      end
      OP_FFEV: begin
        if (stat.fit) begin
          ng    <= cur;
          onext <= r_next;
          sreg  <= s_ff;
          rl    <= start;
        end else begin
          cur <= r_next;
        end
      end
      OP_RLEV: begin
        if (stat.rl_stop) begin
          hint <= rl;
          if (kind == KIND_ALLOC) begin
            res_result <= pay(ng);
          end else if (mv) begin
            res_result <= pay(ng);
            res_moved  <= 1'b1;
            res_old    <= pay(g);
            res_copy   <= copyb;
          end
        end else begin
          rl <= r_next;
        end
      end
      OP_LCHK: begin
        if (stat.addr_bad) res_status <= STATUS_BADADDR;
        cur <= '0;
      end
      OP_LEV: begin
        if (stat.found) begin
          g     <= t;
          gprev <= r_prev;
          gnext <= r_next;
        end else if (stat.cont) begin
          cur <= r_next;
        end else begin
          res_status <= STATUS_BADADDR;
        end
      end
      OP_RCHK: begin
        if (stat.rsz_bad) res_status <= STATUS_SIZE;
        copyb <= copy_c;
      end
      OP_RA1: begin
        if (stat.move) begin
          mv    <= 1'b1;
          start <= hint;
          cur   <= hint;
        end else begin
          gnext <= r_next;
        end
      end
      OP_SC: begin
        res_result <= pay(g);
        if (stat.sc_split) begin
          sreg  <= s_sc;
          onext <= gnext;
          gnext <= s_sc;
          rl    <= s_sc;
        end else begin
          rl <= gnext;
        end
      end
      OP_S3: onext2 <= r_next;
      OP_RG2: begin
        gprev <= r_prev;
        gnext <= r_next;
      end
      OP_R1: begin
        if (!r_used) gnext <= r_next;
      end
      OP_R4: begin
        if (!r_used) g <= gprev;
      end
      OP_R6: begin
        if (g < hint) hint <= g;
      end
      default: begin
      end
    endcase
  end

  // Heap length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_units <= HEAP_UNITS_RST;
    end else if (cfg_we) begin
      heap_units <= cfg_wdata;
    end
  end

  // Output register; a finished result waits here until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_status <= res_status;
      rsp_result <= res_result;
      rsp_moved  <= res_moved;
      rsp_old    <= res_old;
      rsp_copy   <= res_copy;
    end
  end

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for first_fit_heap_allocator_core: directed and random requests.
// Depends on fha_pkg and the request and result interfaces fha_req_if and fha_rsp_if.
// A built-in model of the heap predicts each result; every transfer is checked in order.
module tb;
  import fha_pkg::*;

  localparam int HMAX = HEAP_UNITS_MAX_DEF;
  localparam int ALIGN = ALIGN_BYTES_DEF;
  localparam int HDR = HEADER_UNITS_DEF;
  localparam int MINSPLIT = MIN_SPLIT_UNITS_DEF;
  localparam int IDLE_LIMIT = 200000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] result_address;
    logic              moved;
    logic [ADDR_W-1:0] old_address;
    logic [ADDR_W-1:0] copy_bytes;
  } heap_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  fha_req_if req ();
  fha_rsp_if rsp ();

  first_fit_heap_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Model of the heap: one header per granule.
  bit          blk_used [HMAX];
  int unsigned blk_prev [HMAX];
  int unsigned blk_next [HMAX];
  int unsigned free_hint;
  int unsigned end_gran;
  int unsigned live_addr[$];
  heap_result_t pending_results[$];

  bit failed;
  bit idle_on;
  int quiet_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void heap_rebuild(int unsigned len);
    if (len < 2 * HDR) len = 2 * HDR;
    if (len > HMAX) len = HMAX;
    end_gran = len - HDR;
    blk_used[0] = 1'b0;
    blk_prev[0] = end_gran;
    blk_next[0] = end_gran;
    blk_used[end_gran] = 1'b1;
    blk_prev[end_gran] = 0;
    blk_next[end_gran] = 0;
    free_hint = 0;
    live_addr.delete();
  endfunction

  function automatic void merge_next(int unsigned g);
    int unsigned nn;
    nn = blk_next[blk_next[g]];
    blk_prev[nn] = g;
    blk_next[g] = nn;
  endfunction

  function automatic void split_block(int unsigned g, int unsigned s);
    blk_used[s] = 1'b0;
    blk_prev[s] = g;
    blk_next[s] = blk_next[g];
    blk_prev[blk_next[g]] = s;
    blk_next[g] = s;
  endfunction

  function automatic void advance_hint(int unsigned g);
    for (int steps = 0; steps <= HMAX; steps++) begin
      if (!blk_used[g] || blk_next[g] == end_gran) break;
      g = blk_next[g];
    end
    free_hint = g;
  endfunction

  function automatic bit first_fit(int unsigned units, output int unsigned got);
    int unsigned start;
    int unsigned cur;
    int unsigned want;
    start = free_hint;
    cur = start;
    want = HDR + units;
    got = 0;
    for (int steps = 0; cur != end_gran && steps <= HMAX; steps++) begin
      if (!blk_used[cur] && blk_next[cur] > cur && blk_next[cur] - cur >= want) begin
        blk_used[cur] = 1'b1;
        if (blk_next[cur] >= cur + want && blk_next[cur] - (cur + want) >= MINSPLIT)
          split_block(cur, cur + want);
        advance_hint(start);
        got = cur;
        return 1'b1;
      end
      cur = blk_next[cur];
    end
    return 1'b0;
  endfunction

  function automatic void free_block(int unsigned g);
    blk_used[g] = 1'b0;
    if (!blk_used[blk_next[g]]) merge_next(g);
    if (!blk_used[blk_prev[g]]) begin
      g = blk_prev[g];
      merge_next(g);
    end
    if (g < free_hint) free_hint = g;
  endfunction

  function automatic bit find_block(int unsigned addr, output int unsigned g);
    int unsigned q;
    int unsigned t;
    int unsigned cur;
    g = 0;
    cur = 0;
    if (addr % ALIGN != 0) return 1'b0;
    q = addr / ALIGN;
    if (q < HDR || q >= end_gran) return 1'b0;
    t = q - HDR;
    for (int steps = 0; cur < t && cur != end_gran && steps <= HMAX; steps++)
      cur = blk_next[cur];
    if (cur != t || !blk_used[t]) return 1'b0;
    g = t;
    return 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] payload_addr(int unsigned g);
    return ADDR_W'((g + HDR) * ALIGN);
  endfunction

  function automatic void drop_live(int unsigned addr);
    foreach (live_addr[i]) begin
      if (live_addr[i] == addr) begin
        live_addr.delete(i);
        break;
      end
    end
  endfunction

  // Works out the result of one request and updates the model.
  function automatic heap_result_t predict_request(logic [KIND_W-1:0] kind,
                                                   logic [SIZE_W-1:0] size,
                                                   logic [ADDR_W-1:0] addr);
    heap_result_t r;
    int unsigned units;
    int unsigned g;
    int unsigned ng;
    int unsigned blk_len;
    int unsigned want;
    int unsigned n;
    int unsigned s;
    r = '0;
    units = (int'(size) + ALIGN - 1) / ALIGN;
    case (kind)
      KIND_ALLOC: begin
        if (units == 0 || units > end_gran) r.status = STATUS_SIZE;
        else if (!first_fit(units, ng)) r.status = STATUS_NOMEM;
        else begin
          r.result_address = payload_addr(ng);
          live_addr.push_back(r.result_address);
        end
      end
      KIND_FREE: begin
        if (!find_block(addr, g)) r.status = STATUS_BADADDR;
        else begin
          free_block(g);
          drop_live(addr);
        end
      end
      KIND_REALLOC: begin
        if (!find_block(addr, g)) r.status = STATUS_BADADDR;
        else if (units > end_gran) r.status = STATUS_SIZE;
        else begin
          blk_len = blk_next[g] - g;
          want = HDR + units;
          if (want > blk_len) begin
            n = blk_next[g];
            if (blk_used[n] || want > blk_next[n] - g) begin
              // The block cannot grow in place, so it moves.
              if (!first_fit(units, ng)) begin
                r.status = STATUS_NOMEM;
                return r;
              end
              r.result_address = payload_addr(ng);
              r.moved = 1'b1;
              r.old_address = payload_addr(g);
              r.copy_bytes = blk_len > HDR ? ADDR_W'((blk_len - HDR) * ALIGN) : '0;
              free_block(g);
              drop_live(addr);
              live_addr.push_back(r.result_address);
              return r;
            end
            merge_next(g);
          end
          s = g + want;
          if (blk_next[g] >= s && blk_next[g] - s >= MINSPLIT) begin
            split_block(g, s);
            if (!blk_used[blk_next[s]]) merge_next(s);
          end
          if (g < free_hint) advance_hint(blk_next[g]);
          r.result_address = payload_addr(g);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // Predicts on each request transfer and checks each result transfer.
  always @(posedge clk) begin
    heap_result_t want_r;
    if (!rst) begin
      if (cfg_we) heap_rebuild(cfg_wdata);
      if (req.valid && req.ready)
        pending_results.push_back(predict_request(req.kind, req.size_bytes,
                                                  req.address_bytes));
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d", $time, rsp.status);
          failed = 1'b1;
        end else begin
          want_r = pending_results.pop_front();
          check_field("status", want_r.status, rsp.status);
          check_field("result_address", want_r.result_address, rsp.result_address);
          check_field("moved", want_r.moved, rsp.moved);
          check_field("old_address", want_r.old_address, rsp.old_address);
          check_field("copy_bytes", want_r.copy_bytes, rsp.copy_bytes);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
      quiet_cycles <= 0;
    else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: stalls of random length.
  initial begin
    int stall;
    stall = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else begin
        rsp.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic send_item(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] size,
                           logic [ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= kind;
    req.size_bytes <= size;
    req.address_bytes <= addr;
    do @(posedge clk); while (!(req.valid && req.ready));
  endtask

  // Lowers valid and waits until every expected result has been transferred.
  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_heap_len(logic [CFG_W-1:0] len);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] any_live();
    if (live_addr.size() == 0) return ADDR_W'(HDR * ALIGN);
    return live_addr[$urandom_range(0, live_addr.size() - 1)];
  endfunction

  // Corner cases on the full heap after reset.
  task automatic test_reset_heap();
    logic [ADDR_W-1:0] a;
    send_item(KIND_ALLOC, 16'd1, '0);
    a = any_live();
    send_item(KIND_ALLOC, 16'd0, '0);
    send_item(KIND_ALLOC, 16'hFFFF, 14'h3FFF);
    send_item(KIND_FREE, '0, 14'd13);
    send_item(KIND_FREE, '0, 14'd0);
    send_item(KIND_FREE, '0, 14'h3FFF);
    send_item(KIND_REALLOC, 16'd40, a);
    send_item(KIND_REALLOC, 16'hFFFF, any_live());
    send_item(KIND_REALLOC, 16'd0, any_live());
    send_item(KIND_UNUSED, 16'hFFFF, 14'h3FFF);
    send_item(KIND_FREE, '0, any_live());
    send_item(KIND_FREE, '0, 14'd12);
  endtask

  // Clamped and minimal heap lengths.
  task automatic test_tiny_heap();
    write_heap_len(13'd0);
    send_item(KIND_ALLOC, 16'd1, '0);
    write_heap_len(13'd7);
    send_item(KIND_ALLOC, 16'd4, '0);
    send_item(KIND_ALLOC, 16'd1, '0);
    send_item(KIND_REALLOC, 16'd5, 14'd12);
    write_heap_len(13'h1FFF);
    send_item(KIND_ALLOC, 16'd16372, '0);
    send_item(KIND_ALLOC, 16'd1, '0);
  endtask

  // Grow into a free neighbour, shrink in place and move.
  task automatic test_realloc_paths();
    logic [ADDR_W-1:0] a0;
    logic [ADDR_W-1:0] a1;
    write_heap_len(13'd64);
    send_item(KIND_ALLOC, 16'd8, '0);
    send_item(KIND_ALLOC, 16'd8, '0);
    send_item(KIND_ALLOC, 16'd8, '0);
    drain();
    a0 = live_addr[0];
    a1 = live_addr[1];
    send_item(KIND_FREE, '0, a1);
    send_item(KIND_REALLOC, 16'd24, a0);
    send_item(KIND_REALLOC, 16'd4, a0);
    send_item(KIND_REALLOC, 16'd120, a0);
    send_item(KIND_REALLOC, 16'd400, any_live());
  endtask

  // Mostly well-formed traffic on live blocks, with some noise.
  task automatic test_random(logic [CFG_W-1:0] len, int count);
    int r;
    logic [SIZE_W-1:0] size;
    write_heap_len(len);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 50) begin
        idle_on = ~idle_on;
        drain();
      end
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 8) size = 16'($urandom_range(1, 64));
      else size = 16'($urandom_range(0, 4 * end_gran + 8));
      if (live_addr.size() > 40) r = 50;
      if (r < 45 || live_addr.size() == 0 && r < 92)
        send_item(KIND_ALLOC, size, 14'($urandom));
      else if (r < 75)
        send_item(KIND_FREE, 16'($urandom), any_live());
      else if (r < 92)
        send_item(KIND_REALLOC, size, any_live());
      else
        send_item(2'($urandom), 16'($urandom), 14'($urandom));
    end
  endtask

  initial begin
    failed = 1'b0;
    idle_on = 1'b1;
    quiet_cycles = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.kind = KIND_ALLOC;
    req.size_bytes = '0;
    req.address_bytes = '0;
    heap_rebuild(HEAP_UNITS_RST);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_heap();
    test_tiny_heap();
    test_realloc_paths();
    test_random(13'd64, 300);
    test_random(13'd300, 400);
    test_random(13'h1000, 400);
    test_random(13'(6 + $urandom_range(0, 1000)), 300);
    test_random(13'd20, 200);

    drain();
    if (!failed && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
